[design/rde_pkg.sv]
// Shared types, codes and sizing constants for the raster draw engine.
package rde_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int COORD_W = 14;   // working coordinate, holds corner sums
  localparam int DIM_W   = 13;   // active frame size, up to 4096
  localparam int ERR_W   = 18;   // Bresenham error term and doubled error
  localparam int PROD_W  = 2 * DIM_W;
  localparam int PIX_W   = 32;
  localparam int FW_W    = 10;
  localparam int FH_W    = 9;

  localparam int GRID_STEP = 10;

  localparam logic [2:0] MODE_PIXEL   = 3'd0;
  localparam logic [2:0] MODE_LINE    = 3'd1;
  localparam logic [2:0] MODE_OUTLINE = 3'd2;
  localparam logic [2:0] MODE_FILL    = 3'd3;
  localparam logic [2:0] MODE_GRID    = 3'd4;
  localparam logic [2:0] MODE_CLEAR   = 3'd5;
  localparam logic [2:0] MODE_READ    = 3'd6;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [11:0] x_a;
    logic signed [11:0] y_a;
    logic signed [11:0] x_b;
    logic signed [11:0] y_b;
    logic [PIX_W-1:0]  color;
  } cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] read_data;
    logic             status;
  } rsp_t;

endpackage

[design/rde_ram.sv]
// Generic single-port RAM with registered read data.
module rde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/rde_line.sv]
// Bresenham stepping unit: one pixel position per cycle along a line while advance is high.
module rde_line (
  input  logic                               clk,
  input  logic                               load,
  input  logic                               advance,
  input  logic signed [rde_pkg::COORD_W-1:0] x0,
  input  logic signed [rde_pkg::COORD_W-1:0] y0,
  input  logic signed [rde_pkg::COORD_W-1:0] x1,
  input  logic signed [rde_pkg::COORD_W-1:0] y1,
  output logic signed [rde_pkg::COORD_W-1:0] x,
  output logic signed [rde_pkg::COORD_W-1:0] y,
  output logic                               last
);

  localparam int EXT = rde_pkg::ERR_W - rde_pkg::COORD_W;
  localparam logic signed [rde_pkg::COORD_W-1:0] COORD_ONE = rde_pkg::COORD_W'(1);

  logic signed [rde_pkg::COORD_W-1:0] xe, ye;
  logic signed [rde_pkg::ERR_W-1:0]   dx, dy, err;
  logic                               sx, sy;
  logic signed [rde_pkg::ERR_W-1:0]   ex0, ey0, ex1, ey1, ldx, ldy, e2, err_next;
  logic                               step_x, step_y;

  always_comb begin
    ex0 = $signed({{EXT{x0[rde_pkg::COORD_W-1]}}, x0});
    ey0 = $signed({{EXT{y0[rde_pkg::COORD_W-1]}}, y0});
    ex1 = $signed({{EXT{x1[rde_pkg::COORD_W-1]}}, x1});
    ey1 = $signed({{EXT{y1[rde_pkg::COORD_W-1]}}, y1});
    ldx = (ex1 > ex0) ? ex1 - ex0 : ex0 - ex1;
    ldy = (ey1 > ey0) ? ey1 - ey0 : ey0 - ey1;
    e2 = err <<< 1;
    step_x = e2 > -dy;
    step_y = e2 < dx;
    err_next = err;
    if (step_x) begin
      err_next = err_next - dy;
    end
    if (step_y) begin
      err_next = err_next + dx;
    end
    last = (x == xe) && (y == ye);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x   <= x0;
      y   <= y0;
      xe  <= x1;
      ye  <= y1;
      dx  <= ldx;
      dy  <= ldy;
      sx  <= x0 < x1;
      sy  <= y0 < y1;
      err <= ldx - ldy;
    end else if (advance && !last) begin
      err <= err_next;
      if (step_x) begin
        x <= sx ? x + COORD_ONE : x - COORD_ONE;
      end
      if (step_y) begin
        y <= sy ? y + COORD_ONE : y - COORD_ONE;
      end
    end
  end

endmodule

[design/rde_addr.sv]
// Clipping and address stage: frame check, width*y+x, registered toward the RAM.
module rde_addr #(
  parameter int ADDR_W = 17
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               valid,
  input  logic                               write,
  input  logic                               direct,
  input  logic [ADDR_W-1:0]                  daddr,
  input  logic signed [rde_pkg::COORD_W-1:0] x,
  input  logic signed [rde_pkg::COORD_W-1:0] y,
  input  logic [rde_pkg::PIX_W-1:0]          data,
  input  logic [rde_pkg::DIM_W-1:0]          aw,
  input  logic [rde_pkg::DIM_W-1:0]          ah,
  output logic                               ram_we,
  output logic [ADDR_W-1:0]                  ram_addr,
  output logic [rde_pkg::PIX_W-1:0]          ram_wdata,
  output logic                               oob
);

  logic                             in_frame;
  logic [rde_pkg::PROD_W-1:0]       prod;
  logic [ADDR_W-1:0]                pix_addr;
  logic signed [rde_pkg::COORD_W:0] saw, sah;

  always_comb begin
    saw = $signed({2'b00, aw});
    sah = $signed({2'b00, ah});
    in_frame = (x >= 0) && (y >= 0) && (x < saw) && (y < sah);
    prod = aw * y[rde_pkg::DIM_W-1:0];
    pix_addr = prod[ADDR_W-1:0] + ADDR_W'(x[rde_pkg::DIM_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_we <= 1'b0;
    end else begin
      ram_we <= valid && write && (direct || in_frame);
    end
    ram_addr  <= direct ? daddr : pix_addr;
    ram_wdata <= data;
    if (valid) begin
      oob <= !in_frame;
    end
  end

endmodule

[design/raster_draw_engine_core.sv]
// Top level of the raster draw engine: command sequencer, line unit, address stage and frame RAM.
//
// The engine draws into a frame RAM of MAX_WIDTH*MAX_HEIGHT 32-bit pixels and takes one
// command beat at a time; cmd_stall stays high from the accepted beat until its single
// response beat has been loaded into the output register. Pixels are produced one per clock
// by a single sequencer that walks the shape: a pixel or a read touches one position, a line
// walks max(|dx|,|dy|)+1 positions (all positions are walked, even those clipped off the
// frame), an outline walks its four sides with a load step before each side, a filled
// rectangle walks its clipped area, the grid visits each grid point, and clear sweeps every
// RAM word through the single write port. After reset the same sweep writes zero to the
// whole RAM, and no command beat is accepted until it is done; configuration writes are
// taken at any time. frame_width and frame_height are clamped to the maximum sizes, and
// addresses are the clamped width*y+x, so changing the frame size reinterprets the stored
// pixels.
module raster_draw_engine_core #(
  parameter int MAX_WIDTH  = rde_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rde_pkg::DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  rde_pkg::cmd_t            cmd,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output rde_pkg::rsp_t            rsp,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [rde_pkg::FW_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = rde_pkg::COORD_W;
  localparam int DW     = rde_pkg::DIM_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [DW-1:0] MAX_W_C = DW'(MAX_WIDTH);
  localparam logic [DW-1:0] MAX_H_C = DW'(MAX_HEIGHT);
  localparam logic signed [CW-1:0] ONE_C  = CW'(1);
  localparam logic signed [CW-1:0] STEP_C = CW'(rde_pkg::GRID_STEP);

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_LOAD, S_LINE, S_FILL, S_GRID, S_CLEAR,
    S_READ, S_RWAIT, S_RCAP, S_DRAIN, S_DONE
  } state_t;

  state_t state;

  // Configuration registers and the clamped active frame size.
  logic [rde_pkg::FW_W-1:0] frame_width;
  logic [rde_pkg::FH_W-1:0] frame_height;
  logic [DW-1:0]            aw, ah;
  logic signed [CW:0]       saw, sah;

  always_comb begin
    aw = (DW'(frame_width) > MAX_W_C) ? MAX_W_C : DW'(frame_width);
    ah = (DW'(frame_height) > MAX_H_C) ? MAX_H_C : DW'(frame_height);
    saw = $signed({2'b00, aw});
    sah = $signed({2'b00, ah});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rde_pkg::FW_W'(320);
      frame_height <= rde_pkg::FH_W'(240);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rde_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        rde_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[rde_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Command fields widened to the working coordinate size.
  rde_pkg::cmd_t         cur;
  logic signed [CW-1:0]  xa, ya, xb, yb, cx1, cy1;
  logic signed [CW-1:0]  nxa, nya, nxb, nyb, nxe, nye, nxs, nys;
  logic                  fill_go;

  always_comb begin
    xa  = CW'(cur.x_a);
    ya  = CW'(cur.y_a);
    xb  = CW'(cur.x_b);
    yb  = CW'(cur.y_b);
    cx1 = xa + xb;
    cy1 = ya + yb;
    // Clipped bounds of a filled rectangle for the beat being accepted.
    nxa = CW'(cmd.x_a);
    nya = CW'(cmd.y_a);
    nxb = CW'(cmd.x_b);
    nyb = CW'(cmd.y_b);
    nxs = (nxa < 0) ? '0 : nxa;
    nys = (nya < 0) ? '0 : nya;
    nxe = ((nxa + nxb) > saw) ? saw[CW-1:0] : nxa + nxb;
    nye = ((nya + nyb) > sah) ? sah[CW-1:0] : nya + nyb;
    fill_go = (nxb > 0) && (nyb > 0) && (nxs < nxe) && (nys < nye);
  end

  // Endpoints for the line unit: one segment for pixel and line, four for an outline.
  logic [1:0]           seg;
  logic signed [CW-1:0] lx0, ly0, lx1, ly1;

  always_comb begin
    lx0 = xa;
    ly0 = ya;
    lx1 = xa;
    ly1 = ya;
    if (cur.mode == rde_pkg::MODE_LINE) begin
      lx1 = xb;
      ly1 = yb;
    end else if (cur.mode == rde_pkg::MODE_OUTLINE) begin
      unique case (seg)
        2'd0: begin lx0 = xa;  ly0 = ya;  lx1 = cx1; ly1 = ya;  end
        2'd1: begin lx0 = cx1; ly0 = ya;  lx1 = cx1; ly1 = cy1; end
        2'd2: begin lx0 = cx1; ly0 = cy1; lx1 = xa;  ly1 = cy1; end
        default: begin lx0 = xa; ly0 = cy1; lx1 = xa; ly1 = ya; end
      endcase
    end
  end

  logic signed [CW-1:0] lx, ly;
  logic                 line_last;

  rde_line u_line (
    .clk     (clk),
    .load    (state == S_LOAD),
    .advance (state == S_LINE),
    .x0      (lx0),
    .y0      (ly0),
    .x1      (lx1),
    .y1      (ly1),
    .x       (lx),
    .y       (ly),
    .last    (line_last)
  );

  // Rectangle, grid and sweep counters.
  logic signed [CW-1:0] fx, fy, fxs, fxe, fye;
  logic [ADDR_W-1:0]    sweep;

  // Pixel request toward the address stage.
  logic                     req_valid, req_write, req_direct;
  logic signed [CW-1:0]     req_x, req_y;
  logic [rde_pkg::PIX_W-1:0] req_data;

  always_comb begin
    req_valid  = 1'b0;
    req_write  = 1'b1;
    req_direct = 1'b0;
    req_x      = fx;
    req_y      = fy;
    req_data   = cur.color;
    unique case (state)
      S_WIPE: begin
        req_valid  = 1'b1;
        req_direct = 1'b1;
        req_data   = '0;
      end
      S_CLEAR: begin
        req_valid  = 1'b1;
        req_direct = 1'b1;
      end
      S_LINE: begin
        req_valid = 1'b1;
        req_x     = lx;
        req_y     = ly;
      end
      S_FILL, S_GRID: req_valid = 1'b1;
      S_READ: begin
        req_valid = 1'b1;
        req_write = 1'b0;
        req_x     = xa;
        req_y     = ya;
      end
      default: ;
    endcase
  end

  logic                      ram_we, oob;
  logic [ADDR_W-1:0]         ram_addr;
  logic [rde_pkg::PIX_W-1:0] ram_wdata, ram_rdata;

  rde_addr #(.ADDR_W(ADDR_W)) u_addr (
    .clk       (clk),
    .rst       (rst),
    .valid     (req_valid),
    .write     (req_write),
    .direct    (req_direct),
    .daddr     (sweep),
    .x         (req_x),
    .y         (req_y),
    .data      (req_data),
    .aw        (aw),
    .ah        (ah),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .oob       (oob)
  );

  rde_ram #(.WIDTH(rde_pkg::PIX_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // The response held until the command's work has drained through the RAM.
  rde_pkg::rsp_t res;

  assign cmd_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WIPE;
      sweep     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A beat taken while the next response is ready is replaced in S_DONE instead.
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_WIPE: begin
          sweep <= sweep + 1'b1;
          if (sweep == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            res   <= '0;
            seg   <= '0;
            sweep <= '0;
            unique case (cmd.mode)
              rde_pkg::MODE_PIXEL, rde_pkg::MODE_LINE, rde_pkg::MODE_OUTLINE:
                state <= S_LOAD;
              rde_pkg::MODE_FILL: begin
                fx  <= nxs;
                fy  <= nys;
                fxs <= nxs;
                fxe <= nxe;
                fye <= nye;
                state <= fill_go ? S_FILL : S_DONE;
              end
              rde_pkg::MODE_GRID: begin
                fx    <= '0;
                fy    <= '0;
                state <= ((aw != '0) && (ah != '0)) ? S_GRID : S_DONE;
              end
              rde_pkg::MODE_CLEAR: state <= S_CLEAR;
              rde_pkg::MODE_READ:  state <= S_READ;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_LOAD: state <= S_LINE;
        S_LINE: begin
          if (line_last) begin
            if ((cur.mode == rde_pkg::MODE_OUTLINE) && (seg != 2'd3)) begin
              seg   <= seg + 1'b1;
              state <= S_LOAD;
            end else begin
              state <= S_DRAIN;
            end
          end
        end
        S_FILL: begin
          if (fx + ONE_C >= fxe) begin
            fx <= fxs;
            fy <= fy + ONE_C;
            if (fy + ONE_C >= fye) begin
              state <= S_DRAIN;
            end
          end else begin
            fx <= fx + ONE_C;
          end
        end
        S_GRID: begin
          if (fx + STEP_C >= saw[CW-1:0]) begin
            fx <= '0;
            fy <= fy + STEP_C;
            if (fy + STEP_C >= sah[CW-1:0]) begin
              state <= S_DRAIN;
            end
          end else begin
            fx <= fx + STEP_C;
          end
        end
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == LAST_ADDR) begin
            state <= S_DRAIN;
          end
        end
        S_READ:  state <= S_RWAIT;
        S_RWAIT: begin
          res.status <= oob;
          state      <= S_RCAP;
        end
        S_RCAP: begin
          res.read_data <= res.status ? '0 : ram_rdata;
          state         <= S_DONE;
        end
        S_DRAIN: state <= S_DONE;
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
